FILE: src/assert_macros.svh
// assertion macros for the hash unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// constants, round table and shared types of the hash unit
// ----------------------------------------------------------------------------
package sha_pkg;
    localparam int unsigned LenBitsDefault = 64;
    localparam int unsigned QueueDepth = 4;

    // command from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_pad;   // end of message: padding and output
    } cmd_t;

    localparam logic [255:0] InitHash = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    function automatic logic [31:0] init_word(input logic [2:0] i);
        return InitHash[255 - 32 * i -: 32];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
            6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
            6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
            6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
            6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
            6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
            6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
            6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
            6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
            6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
            6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
            6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction
endpackage

FILE: src/sha256_hash_unit.sv
// a byte beat is absorbed in S_IDLE; a full block then goes through S_ROUND and S_FOLD
// end of message: zero padding in S_PAD, one or two compressions, 8 output beats
// a byte-with-end beat stalls the input while the front queues its end marker
// throughput set by the one-round-per-cycle compression loop; the back takes no byte while it compresses
// reset: asynchronous active low, hash state back to the initial values, queue empty
// ----------------------------------------------------------------------------
// sha256_hash_unit
// streaming sha-256: front classifies beats, queue decouples, back hashes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_hash_unit
#(
    parameter int unsigned LENGTH_COUNTER_BITS = sha_pkg::LenBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);
    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    sha_pkg::cmd_t fq_cmd, qb_cmd;
    logic [3:0]    out_user;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd));

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(fq_valid), .in_ready(fq_ready),
        .in_cmd(fq_cmd), .out_valid(qb_valid), .out_ready(qb_ready), .out_cmd(qb_cmd));

    sha_back #(.LEN_BITS(LENGTH_COUNTER_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qb_valid), .q_ready(qb_ready),
        .q_cmd(qb_cmd), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(out_user));

    assign m_tuser = out_user[2:0];
    assign m_tlast = out_user[3];

    `ASSERT_IMPLIES(a_last_idx, clk, rst_n, m_tvalid && m_tlast, m_tuser == 3'd7)
    `ASSERT_NEXT(a_idx_step, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)
    `ASSERT_IMPLIES(a_no_take_out, clk, rst_n, m_tvalid, !qb_ready)
endmodule

FILE: src/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// accepts input beats, drops idle beats and splits a byte-with-end beat
// ----------------------------------------------------------------------------
module sha_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    input  logic            s_tlast,
    output logic            q_valid,
    input  logic            q_ready,
    output sha_pkg::cmd_t   q_cmd
);
    // pending end marker after the byte of a byte-with-end beat
    logic pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        s_tready  = !pend_reg && q_ready;
        q_valid   = 1'b0;
        q_cmd     = '0;
        if (pend_reg)
        begin
            q_valid      = 1'b1;
            q_cmd.is_pad = 1'b1;
            if (q_ready)
                pend_next = 1'b0;
        end
        else if (s_tvalid)
        begin
            q_valid   = s_tuser || s_tlast;
            q_cmd.data   = s_tdata;
            q_cmd.is_pad = !s_tuser;
            if (q_ready && s_tuser && s_tlast)
                pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end
endmodule

FILE: src/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// short fifo of commands between front and back
// ----------------------------------------------------------------------------
module sha_queue
#(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sha_pkg::cmd_t   in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output sha_pkg::cmd_t   out_cmd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::cmd_t    mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

FILE: src/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// block assembly, padding, 64-round compression and digest output
// ----------------------------------------------------------------------------
module sha_back
#(
    parameter int unsigned LEN_BITS = sha_pkg::LenBitsDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  sha_pkg::cmd_t   q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic [3:0]      m_tuser
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     h_reg [8];
    logic [31:0]     w_reg [16];
    logic [31:0]     v_reg [8];
    logic [5:0]      fill_reg;
    logic [60:0]     cnt_reg;
    logic [5:0]      rnd_reg;
    logic            pad_reg;    // closing a message
    logic            last_reg;   // current block carries the length
    logic [2:0]      oidx_reg;

    logic [63:0] bits;
    logic [31:0] wi, s0, s1, t1, t2, e, a, ch, mj, wnew, w2, w15;
    logic [3:0]  widx;

    always_comb
    begin
        bits = {cnt_reg, 3'b000};
        if (LEN_BITS < 64)
            bits = bits & ({64{1'b1}} >> (64 - LEN_BITS));
    end

    assign widx = fill_reg[5:2];

    // message schedule kept in a rolling 16-word window, plus the round function terms
    always_comb
    begin
        w2   = w_reg[14];
        w15  = w_reg[1];
        s0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        wi   = w_reg[0];
        a    = v_reg[0];
        e    = v_reg[4];
        ch   = (e & v_reg[5]) ^ (~e & v_reg[6]);
        mj   = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ch + sha_pkg::round_k(rnd_reg) + wi;
        t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) + mj;
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = h_reg[oidx_reg];
    assign m_tuser  = {oidx_reg == 3'd7, oidx_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                begin
                    // a full block is compressed first, even when it ends in the marker
                    if (fill_reg == 6'd63)
                        state_next = S_ROUND;
                    else if (q_cmd.is_pad)
                        state_next = S_PAD;
                end
            S_PAD:
                if (fill_reg == 6'd56 || fill_reg == 6'd63)
                    state_next = S_ROUND;
            S_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = S_FOLD;
            S_FOLD:
                state_next = last_reg ? S_OUT : (pad_reg ? S_PAD : S_IDLE);
            S_OUT:
                if (m_tready && oidx_reg == 3'd7)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // payload: block words, working vars
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE && q_valid && !q_cmd.is_pad) ||
            (state_reg == S_PAD && fill_reg != 6'd56))
        begin
            unique case (fill_reg[1:0])
                2'd0: w_reg[widx][31:24] <= (state_reg == S_PAD) ? 8'h00 : q_cmd.data;
                2'd1: w_reg[widx][23:16] <= (state_reg == S_PAD) ? 8'h00 : q_cmd.data;
                2'd2: w_reg[widx][15:8]  <= (state_reg == S_PAD) ? 8'h00 : q_cmd.data;
                default: w_reg[widx][7:0] <= (state_reg == S_PAD) ? 8'h00 : q_cmd.data;
            endcase
        end
        if (state_reg == S_IDLE && q_valid && q_cmd.is_pad)
            w_reg[widx][31 - 8 * fill_reg[1:0] -: 8] <= 8'h80;
        if (state_reg == S_PAD && fill_reg == 6'd56)
        begin
            w_reg[14] <= bits[63:32];
            w_reg[15] <= bits[31:0];
        end
        if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
            for (int i = 1; i < 8; i++)
                v_reg[i] <= v_reg[i - 1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha_pkg::init_word(3'(i));
            fill_reg <= '0;
            cnt_reg  <= '0;
            rnd_reg  <= '0;
            pad_reg  <= 1'b0;
            last_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        if (q_cmd.is_pad)
                            pad_reg <= 1'b1;
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                S_PAD:
                    if (fill_reg == 6'd56)
                    begin
                        last_reg <= 1'b1;
                        fill_reg <= '0;
                    end
                    else
                        fill_reg <= fill_reg + 1'b1;
                S_ROUND:
                    rnd_reg <= rnd_reg + 1'b1;
                S_FOLD:
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                S_OUT:
                    if (m_tready)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha_pkg::init_word(3'(i));
                            cnt_reg  <= '0;
                            fill_reg <= '0;
                            pad_reg  <= 1'b0;
                            last_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end
endmodule

FILE: bench/sha256_hash_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_unit_tb
// streams byte beats into the hash unit and checks every digest word against
// a behavioral sha-256 kept in the bench, under random stalls on both sides
// ----------------------------------------------------------------------------
module sha256_hash_unit_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    beat_t        pending_beats[$];
    digest_beat_t expected_digests[$];
    int           error_count;
    int           sent_count;
    int           word_count;
    int           message_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_recv;

    // bench copy of the hash state
    logic [31:0] chain[8];
    logic [31:0] blk[16];
    int unsigned fill;
    logic [60:0] byte_total;

    localparam logic [31:0] InitChain[8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [31:0] RoundConst[64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    sha256_hash_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    task automatic compress_chunk();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wi, s0, s1, t1, t2;
        w = blk;
        v = chain;
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wi = w[r];
            else
            begin
                s0 = ror(w[(r - 15) & 15], 7) ^ ror(w[(r - 15) & 15], 18)
                     ^ (w[(r - 15) & 15] >> 3);
                s1 = ror(w[(r - 2) & 15], 17) ^ ror(w[(r - 2) & 15], 19)
                     ^ (w[(r - 2) & 15] >> 10);
                wi = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
                w[r & 15] = wi;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wi;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * (fill % 4);
        blk[fill / 4] = (blk[fill / 4] & ~(32'hFF << sh)) | (32'(b) << sh);
        fill = (fill + 1) % 64;
        if (fill == 0)
            compress_chunk();
    endtask

    // advances the bench hash on one accepted beat, queues digest words on eom
    task automatic hash_beat(input beat_t bt);
        logic [63:0] bit_len;
        if (bt.has_byte)
        begin
            absorb_byte(bt.data);
            byte_total = byte_total + 1'b1;
        end
        if (bt.eom)
        begin
            bit_len = {byte_total, 3'b000};
            absorb_byte(8'h80);
            while (fill != 56)
                absorb_byte(8'h00);
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            fill = 0;
            compress_chunk();
            for (int i = 0; i < 8; i++)
                expected_digests.push_back('{chain[i], 3'(i), i == 7});
            chain = InitChain;
            byte_total = '0;
            message_count++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                hash_beat({s_tdata, s_tuser, s_tlast});
                sent_count++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_t nb;
                    nb = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.data;
                    s_tuser  <= nb.has_byte;
                    s_tlast  <= nb.eom;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                word_count++;
                if (expected_digests.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, 32'h0);
                else
                begin
                    digest_beat_t ex;
                    ex = expected_digests.pop_front();
                    if (m_tdata !== ex.word)
                        report_mismatch("digest_word", m_tdata, ex.word);
                    if (m_tuser !== ex.idx)
                        report_mismatch("word_index", 32'(m_tuser), 32'(ex.idx));
                    if (m_tlast !== ex.last)
                        report_mismatch("last_word", 32'(m_tlast), 32'(ex.last));
                end
            end
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_beat(input logic [7:0] d, input bit hb, input bit eom);
        pending_beats.push_back('{d, hb, eom});
    endtask

    task automatic add_message(input int len, input bit pad_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                add_beat(8'($urandom), 1'b0, 1'b0);
            add_beat(8'($urandom), 1'b1, (i == len - 1) && !pad_end);
        end
        if (pad_end || len == 0)
            add_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_tvalid || expected_digests.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int boundary_len[4];
        error_count = 0;
        sent_count = 0;
        word_count = 0;
        message_count = 0;
        hold_recv = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 67;
        boundary_len = '{55, 56, 63, 64};
        chain = InitChain;
        foreach (blk[i])
            blk[i] = '0;
        fill = 0;
        byte_total = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle beats, byte with end, short messages
        add_beat(8'hFF, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(8'h00, 1'b1, 1'b1);
        add_beat(8'hFF, 1'b1, 1'b1);
        add_beat(8'h61, 1'b1, 1'b0);
        add_beat(8'h62, 1'b1, 1'b0);
        add_beat(8'h63, 1'b1, 1'b1);
        add_message(3, 1'b1);
        add_message(0, 1'b0);
        wait_drained();

        // boundary lengths around the length field and block edge
        foreach (boundary_len[i])
            add_message(boundary_len[i], 1'(i % 2));
        wait_drained();

        // receiver held off while the sender keeps offering
        hold_recv = 1'b1;
        add_message(20, 1'b0);
        add_message(5, 1'b0);
        add_message(7, 1'b1);
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 14 : 0;
            for (int k = 0; k < 30; )
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(70, 57)
                                               : $urandom_range(12);
                add_message(len, $urandom_range(1));
                k += len + 1;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d beats, %0d messages, %0d digest words",
                 sent_count, message_count, word_count);
        $display("directed edges, block boundaries, backpressure and three stall mixes");
        if (error_count == 0)
            $display("sha256_hash_unit_tb: PASS");
        else
            $display("sha256_hash_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("sha256_hash_unit_tb: FAIL");
        $finish;
    end

endmodule
